[sv/cffa_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// cffa_pkg
// shared types, widths and helpers of the circular first-fit slot allocator
// ---------------------------------------------------------------------------
package cffa_pkg;

    localparam int SLOT_W      = 10;
    localparam int COUNT_W     = 11;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;
    localparam int MAX_SLOTS   = 1024;

    // occupancy words and summary words share one group size
    localparam int GRP_LG      = 5;
    localparam int GRP_W       = 1 << GRP_LG;

    typedef enum logic {
        ACT_ENTER = 1'b0,
        ACT_EXIT  = 1'b1
    } t_action;

    typedef struct packed {
        t_action             action;
        logic [SLOT_W-1:0]   slot;
    } t_cmd;

    typedef struct packed {
        logic                idle;
        logic                done;
        logic [SLOT_W-1:0]   granted_slot;
        logic                full_res;
    } t_status;

    // lowest set bit of a group word, zero when none
    function automatic logic [GRP_LG-1:0] first_set(input logic [GRP_W-1:0] v);
        logic [GRP_LG-1:0] idx;
        idx = '0;
        for (int k = GRP_W - 1; k >= 0; k--) begin
            if (v[k]) idx = GRP_LG'(k);
        end
        return idx;
    endfunction

endpackage
`default_nettype wire

[sv/cffa_req_if.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// cffa_req_if
// request channel: enter or exit command with its slot
// ---------------------------------------------------------------------------
interface cffa_req_if;
    logic                        valid;
    logic                        ready;
    logic                        action;
    logic [cffa_pkg::SLOT_W-1:0] slot;

    modport source (output valid, output action, output slot, input ready);
    modport sink   (input valid, input action, input slot, output ready);
endinterface
`default_nettype wire

[sv/cffa_res_if.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// cffa_res_if
// result channel: granted slot and full flag of an enter request
// ---------------------------------------------------------------------------
interface cffa_res_if;
    logic                        valid;
    logic                        ready;
    logic [cffa_pkg::SLOT_W-1:0] granted_slot;
    logic                        full_res;

    modport source (output valid, output granted_slot, output full_res, input ready);
    modport sink   (input valid, input granted_slot, input full_res, output ready);
endinterface
`default_nettype wire

[sv/cffa_engine.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// cffa_engine
// occupancy memories and the search / update sequencer
// ---------------------------------------------------------------------------
module cffa_engine #(
    parameter int MAX_SLOTS = cffa_pkg::MAX_SLOTS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [cffa_pkg::COUNT_W-1:0]  i_slot_count,
    input  wire logic                          i_start,
    input  wire cffa_pkg::t_cmd                i_cmd,
    input  wire logic                          i_res_room,
    output cffa_pkg::t_status                  o_status
);

    localparam int GLG    = cffa_pkg::GRP_LG;
    localparam int GW     = cffa_pkg::GRP_W;
    localparam int BLG    = 2 * GLG;
    localparam int NWORDS = (MAX_SLOTS + GW - 1) / GW;
    localparam int LAW    = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int LDEPTH = 1 << LAW;
    localparam int SAW    = (LAW > GLG) ? LAW - GLG : 1;
    localparam int SDEPTH = 1 << SAW;
    localparam int PW     = SAW + BLG + 1;
    localparam int CW     = (PW > cffa_pkg::COUNT_W) ? PW : cffa_pkg::COUNT_W;

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_SREAD = 8'b0000_0100,
        S_SPICK = 8'b0000_1000,
        S_LCHK  = 8'b0001_0000,
        S_RES   = 8'b0010_0000,
        S_EREAD = 8'b0100_0000,
        S_EWR   = 8'b1000_0000
    } t_state;

    // occupancy words (1 = free) and one summary bit per word (word has a free bit)
    logic [GW-1:0] r_leaf_mem [LDEPTH];
    logic [GW-1:0] r_sum_mem  [SDEPTH];
    logic [GW-1:0] r_ldata, r_sdata;

    t_state           r_state, n_state;
    logic [LAW-1:0]   r_clr_addr, n_clr_addr;
    logic [PW-1:0]    r_lo, n_lo;
    logic [PW-1:0]    r_hi, n_hi;
    logic [PW-1:0]    r_s, n_s;
    logic             r_wrap, n_wrap;
    logic [GLG-1:0]   r_j, n_j;
    logic [PW-1:0]    r_pick, n_pick;
    logic             r_full, n_full;

    logic             leaf_re, leaf_we, sum_re, sum_we;
    logic [LAW-1:0]   leaf_raddr, leaf_waddr;
    logic [SAW-1:0]   sum_raddr, sum_waddr;
    logic [GW-1:0]    leaf_wdata, sum_wdata;

    logic [CW-1:0]    cnt_cw, n_cw, s_cw;
    logic             s_lt_n;
    logic [PW-1:0]    hm1;
    logic [SAW-1:0]   sa_lo, hm1_sa;
    logic [LAW-1:0]   lo_wrd, hm1_wrd, cur_wrd;
    logic [GLG-1:0]   lo_j, hm1_j, lo_b, hm1_b;
    logic [GW-1:0]    smask, lmask, lmasked, lnew;
    logic             lfound;
    logic [GLG-1:0]   lbit;
    logic [SAW:0]     sa_nxt;
    logic [SAW+GLG:0] wrd_nxt;

    // effective count and start slot
    always_comb begin
        cnt_cw = CW'(i_slot_count);
        n_cw   = (cnt_cw > CW'(MAX_SLOTS)) ? CW'(MAX_SLOTS) : cnt_cw;
        s_cw   = CW'(i_cmd.slot);
        s_lt_n = s_cw < n_cw;
    end

    // position decode of the current search window
    always_comb begin
        hm1     = r_hi - PW'(1);
        sa_lo   = SAW'(r_lo >> BLG);
        hm1_sa  = SAW'(hm1 >> BLG);
        lo_wrd  = LAW'(r_lo >> GLG);
        hm1_wrd = LAW'(hm1 >> GLG);
        lo_j    = r_lo[BLG-1:GLG];
        hm1_j   = hm1[BLG-1:GLG];
        lo_b    = r_lo[GLG-1:0];
        hm1_b   = hm1[GLG-1:0];
        cur_wrd = LAW'({sa_lo, r_j});
        sa_nxt  = {1'b0, sa_lo} + (SAW+1)'(1);
        wrd_nxt = {1'b0, sa_lo, r_j} + (SAW+GLG+1)'(1);

        smask = {GW{1'b1}} << lo_j;
        if (hm1_sa == sa_lo) smask = smask & ({GW{1'b1}} >> (GLG'(GW - 1) - hm1_j));

        lmask = {GW{1'b1}};
        if (cur_wrd == lo_wrd)  lmask = lmask & ({GW{1'b1}} << lo_b);
        if (cur_wrd == hm1_wrd) lmask = lmask & ({GW{1'b1}} >> (GLG'(GW - 1) - hm1_b));
        lmasked = r_ldata & lmask;
        lfound  = |lmasked;
        lbit    = cffa_pkg::first_set(lmasked);
        lnew    = r_ldata & ~(GW'(1) << lbit);
    end

    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_lo       = r_lo;
        n_hi       = r_hi;
        n_s        = r_s;
        n_wrap     = r_wrap;
        n_j        = r_j;
        n_pick     = r_pick;
        n_full     = r_full;
        leaf_re    = 1'b0;
        leaf_we    = 1'b0;
        sum_re     = 1'b0;
        sum_we     = 1'b0;
        leaf_raddr = lo_wrd;
        leaf_waddr = cur_wrd;
        leaf_wdata = lnew;
        sum_raddr  = sa_lo;
        sum_waddr  = sa_lo;
        sum_wdata  = r_sdata;

        unique case (r_state)
            S_CLEAR: begin
                leaf_we    = 1'b1;
                leaf_waddr = r_clr_addr;
                leaf_wdata = {GW{1'b1}};
                sum_we     = 1'b1;
                sum_waddr  = r_clr_addr[SAW-1:0];
                sum_wdata  = {GW{1'b1}};
                n_clr_addr = r_clr_addr + LAW'(1);
                if (r_clr_addr == {LAW{1'b1}}) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_start) begin
                    n_full = 1'b0;
                    n_s    = PW'(s_cw);
                    if (i_cmd.action == cffa_pkg::ACT_EXIT) begin
                        n_lo = PW'(s_cw);
                        if (s_lt_n) n_state = S_EREAD;
                    end else begin
                        n_hi    = PW'(n_cw);
                        n_state = S_SREAD;
                        if (s_lt_n) begin
                            n_lo   = PW'(s_cw);
                            n_wrap = (s_cw != '0);
                        end else begin
                            n_lo   = '0;
                            n_wrap = 1'b0;
                        end
                    end
                end
            end
            S_SREAD: begin
                if (r_lo < r_hi) begin
                    sum_re  = 1'b1;
                    n_state = S_SPICK;
                end else if (r_wrap) begin
                    // second pass over the slots below the preferred one
                    n_lo   = '0;
                    n_hi   = r_s;
                    n_wrap = 1'b0;
                end else begin
                    n_full  = 1'b1;
                    n_pick  = '0;
                    n_state = S_RES;
                end
            end
            S_SPICK: begin
                if (|(r_sdata & smask)) begin
                    n_j        = cffa_pkg::first_set(r_sdata & smask);
                    leaf_re    = 1'b1;
                    leaf_raddr = LAW'({sa_lo, cffa_pkg::first_set(r_sdata & smask)});
                    n_state    = S_LCHK;
                end else begin
                    n_lo    = {sa_nxt, {BLG{1'b0}}};
                    n_state = S_SREAD;
                end
            end
            S_LCHK: begin
                if (lfound) begin
                    leaf_we            = 1'b1;
                    sum_we             = 1'b1;
                    sum_wdata          = r_sdata;
                    sum_wdata[r_j]     = |lnew;
                    n_pick             = PW'({sa_lo, r_j, lbit});
                    n_state            = S_RES;
                end else begin
                    // free bits of this word lie outside the window
                    n_lo    = {wrd_nxt, {GLG{1'b0}}};
                    n_state = S_SREAD;
                end
            end
            S_RES: begin
                if (i_res_room) n_state = S_IDLE;
            end
            S_EREAD: begin
                leaf_re = 1'b1;
                sum_re  = 1'b1;
                n_state = S_EWR;
            end
            S_EWR: begin
                leaf_we    = 1'b1;
                leaf_waddr = lo_wrd;
                leaf_wdata = r_ldata | (GW'(1) << lo_b);
                sum_we     = 1'b1;
                sum_wdata  = r_sdata | (GW'(1) << lo_j);
                n_state    = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_wrap     <= 1'b0;
            r_full     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_wrap     <= n_wrap;
            r_full     <= n_full;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo   <= n_lo;
        r_hi   <= n_hi;
        r_s    <= n_s;
        r_j    <= n_j;
        r_pick <= n_pick;
    end

    always_ff @(posedge i_clk) begin
        if (leaf_we) r_leaf_mem[leaf_waddr] <= leaf_wdata;
        if (leaf_re) r_ldata <= r_leaf_mem[leaf_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (sum_we) r_sum_mem[sum_waddr] <= sum_wdata;
        if (sum_re) r_sdata <= r_sum_mem[sum_raddr];
    end

    always_comb begin
        o_status.idle         = (r_state == S_IDLE);
        o_status.done         = (r_state == S_RES) && i_res_room;
        o_status.granted_slot = cffa_pkg::SLOT_W'(r_pick);
        o_status.full_res     = r_full;
    end

    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(leaf_re && leaf_we) && !(sum_re && sum_we))
        else $error("memory read and write in the same cycle");

    a_pick_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SPICK) |-> (r_lo < r_hi))
        else $error("summary pick with an empty window");

    a_one_bit_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LCHK && lfound) |-> ($countones(r_ldata ^ leaf_wdata) == 1))
        else $error("grant changed other than one occupancy bit");

    a_grant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LCHK && lfound) |=> (r_state == S_RES && !r_full))
        else $error("grant did not reach the result state");

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> (r_state == S_IDLE))
        else $error("request started while busy");

endmodule
`default_nettype wire

[sv/circular_first_free_slot_allocator_top.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// circular_first_free_slot_allocator_top
// circular first-fit slot allocator with a request and a result channel
// ---------------------------------------------------------------------------
// Keeps one free bit per slot; the first slot_count slots are in use and all
// are free after reset. An enter request takes the first free slot at or after
// its preferred slot, wrapping to slot 0, and returns it; with no free slot it
// returns full_res=1 and slot 0 and changes nothing. An exit request frees its
// slot and returns nothing; exits at or beyond the count are dropped. Requests
// are taken one at a time. The free bits sit in a word memory (32 slots per
// word) with a summary memory holding one "word has a free slot" bit per word,
// both with registered reads. An enter runs S_SREAD (read a summary word),
// S_SPICK (pick a word, read it), S_LCHK (check and write both back) and
// S_RES, which waits for room in the result register. A probed word whose
// free bits lie outside the search window goes back to S_SREAD, a summary
// word with nothing in the window moves on to the next summary word, and the
// wrap restarts the search at slot 0; a zero count goes straight to a full
// result. An exit reads both words in S_EREAD and writes them back in S_EWR;
// a dropped exit leaves the sequencer idle. After reset a clearing pass of one
// memory word a cycle (32 words at 1024 slots) runs before the first request
// is taken; slot_count may be written meanwhile. The result register lets the
// next request enter while a result is still waiting.
// ---------------------------------------------------------------------------
module circular_first_free_slot_allocator_top #(
    parameter int MAX_SLOTS = cffa_pkg::MAX_SLOTS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [cffa_pkg::COUNT_W-1:0]  i_cfg_wdata,
    cffa_req_if.sink                           i_req,
    cffa_res_if.source                         o_res
);

    // slot count register; the user writes it only while idle, the block does not enforce it
    logic [cffa_pkg::COUNT_W-1:0] r_slot_count;

    // result register
    logic                         r_out_valid, n_out_valid;
    logic [cffa_pkg::SLOT_W-1:0]  r_granted, n_granted;
    logic                         r_full_res, n_full_res;

    cffa_pkg::t_cmd               cmd;
    cffa_pkg::t_status            status;
    logic                         start;
    logic                         res_room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_count <= cffa_pkg::COUNT_RESET;
        end else if (i_cfg_we) begin
            r_slot_count <= i_cfg_wdata;
        end
    end

    // request side: accept only while the sequencer is idle
    assign i_req.ready = status.idle;
    assign start       = i_req.valid && status.idle;
    assign cmd.action  = cffa_pkg::t_action'(i_req.action);
    assign cmd.slot    = i_req.slot;

    // room for a new result when the register is empty or being drained
    assign res_room = !r_out_valid || o_res.ready;

    cffa_engine #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_slot_count (r_slot_count),
        .i_start      (start),
        .i_cmd        (cmd),
        .i_res_room   (res_room),
        .o_status     (status)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        n_granted   = r_granted;
        n_full_res  = r_full_res;
        priority if (status.done) begin
            n_out_valid = 1'b1;
            n_granted   = status.granted_slot;
            n_full_res  = status.full_res;
        end else if (o_res.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_granted  <= n_granted;
        r_full_res <= n_full_res;
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.granted_slot = r_granted;
    assign o_res.full_res     = r_full_res;

endmodule
`default_nettype wire

[bench/tb_circular_first_free_slot_allocator_top.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_circular_first_free_slot_allocator_top
// self-checking bench for the circular first-fit slot allocator
// ---------------------------------------------------------------------------
// A bitmap predictor tracks slot occupancy and the slot count. Every accepted
// enter request queues its predicted grant, and each result is checked against
// the oldest one. Directed cases cover wrap-around, full, out-of-range slots
// and count extremes. A backpressure case and random traffic phases follow,
// each phase at its own slot count.
// ---------------------------------------------------------------------------
module tb_circular_first_free_slot_allocator_top;

    localparam int NO_SLOT    = -1;    // search found nothing
    localparam int MAX_GAP    = 14;    // longest idle draw on either side
    localparam int DRAIN_WAIT = 16;    // covers an exit still in flight
    localparam int HOLD_LEN   = 300;   // long result stall for the pressure case
    localparam int BURST_LEN  = 24;

    typedef struct packed {
        logic [cffa_pkg::SLOT_W-1:0] slot;
        logic                        full;
    } t_grant;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n;
    logic                         i_cfg_we;
    logic [cffa_pkg::COUNT_W-1:0] i_cfg_wdata;

    cffa_req_if req_bus();
    cffa_res_if res_bus();

    circular_first_free_slot_allocator_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_bus),
        .o_res       (res_bus)
    );

    // predictor state: one free bit per slot and the programmed count
    logic [cffa_pkg::MAX_SLOTS-1:0] free_bits;
    logic [cffa_pkg::COUNT_W-1:0]   slot_count;
    t_grant                         pending_grants[$];

    // shared knobs: no idling on either side, and a one-off long result stall
    bit steady_flow = 1'b0;
    int hold_cycles = 0;

    int enters_sent = 0;
    int exits_sent  = 0;
    int grants_seen = 0;
    int fulls_seen  = 0;
    int counts_used = 0;
    int mismatches  = 0;

    always #5 i_clk = ~i_clk;

    // ---------------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------------

    // counts above the slot store saturate
    function automatic int active_count();
        return (int'(slot_count) > cffa_pkg::MAX_SLOTS) ? cffa_pkg::MAX_SLOTS
                                                        : int'(slot_count);
    endfunction

    // first free slot from the preferred one up to the count, then from slot 0;
    // a preferred slot beyond the count starts the search at slot 0
    function automatic t_grant allocate_slot(input logic [cffa_pkg::SLOT_W-1:0] pref);
        int     n;
        int     start;
        int     pick;
        t_grant g;
        n     = active_count();
        start = (int'(pref) < n) ? int'(pref) : 0;
        pick  = NO_SLOT;
        for (int i = start; i < n && pick == NO_SLOT; i++)
            if (free_bits[i]) pick = i;
        for (int i = 0; i < start && pick == NO_SLOT; i++)
            if (free_bits[i]) pick = i;
        if (pick == NO_SLOT) begin
            g.slot = '0;
            g.full = 1'b1;
        end else begin
            free_bits[pick] = 1'b0;
            g.slot = cffa_pkg::SLOT_W'(pick);
            g.full = 1'b0;
        end
        return g;
    endfunction

    // exits beyond the count are dropped
    function automatic void release_slot(input logic [cffa_pkg::SLOT_W-1:0] slot);
        if (int'(slot) < active_count()) free_bits[slot] = 1'b1;
    endfunction

    // ---------------------------------------------------------------------
    // request side
    // ---------------------------------------------------------------------

    // offers one request after a random gap and returns at its accepting edge,
    // with valid still high so back-to-back requests need no extra toggle
    task automatic send_request(input cffa_pkg::t_action act,
                                input logic [cffa_pkg::SLOT_W-1:0] slot);
        int gap;
        gap = steady_flow ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_bus.valid  <= 1'b1;
        req_bus.action <= act;
        req_bus.slot   <= slot;
        do @(posedge i_clk); while (!req_bus.ready);
        if (act == cffa_pkg::ACT_ENTER) begin
            pending_grants.push_back(allocate_slot(slot));
            enters_sent++;
        end else begin
            release_slot(slot);
            exits_sent++;
        end
    endtask

    // drop valid, wait for every grant, then let a trailing exit finish
    task automatic settle_block();
        if (req_bus.valid) req_bus.valid <= 1'b0;
        while (pending_grants.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // count writes only happen with the block idle
    task automatic set_slot_count(input logic [cffa_pkg::COUNT_W-1:0] value);
        settle_block();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        slot_count = value;
        counts_used++;
    endtask

    // ---------------------------------------------------------------------
    // result side
    // ---------------------------------------------------------------------

    // ready drops for a random stall before each result; a pending long hold
    // is counted out here before the next result is taken
    initial begin : result_sink
        int stall;
        res_bus.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = steady_flow ? 0 : $urandom_range(0, MAX_GAP);
            if (hold_cycles > 0) begin
                stall       = hold_cycles;
                hold_cycles = 0;
            end
            if (stall > 0) begin
                res_bus.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_bus.ready <= 1'b1;
            do @(posedge i_clk); while (!res_bus.valid);
        end
    end

    // every result is matched with the oldest predicted grant
    always @(posedge i_clk) begin : result_check
        t_grant want;
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            if (pending_grants.size() == 0) begin
                $display("%0t: unexpected result, expected none, got slot %0d full %0b",
                         $time, res_bus.granted_slot, res_bus.full_res);
                mismatches++;
            end else begin
                want = pending_grants.pop_front();
                if (res_bus.granted_slot !== want.slot) begin
                    $display("%0t: granted_slot mismatch, expected %0d, got %0d",
                             $time, want.slot, res_bus.granted_slot);
                    mismatches++;
                end
                if (res_bus.full_res !== want.full) begin
                    $display("%0t: full_res mismatch, expected %0b, got %0b",
                             $time, want.full, res_bus.full_res);
                    mismatches++;
                end
                if (want.full) fulls_seen++;
                else grants_seen++;
            end
        end
    end

    // ---------------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------------

    // reset count: forward search, wrap to slot 0, exits of taken and free slots
    task automatic test_wrap_search();
        send_request(cffa_pkg::ACT_ENTER, 10'd0);
        send_request(cffa_pkg::ACT_ENTER, 10'd0);      // slot 0 taken, moves on to 1
        send_request(cffa_pkg::ACT_ENTER, 10'd1023);   // top slot
        send_request(cffa_pkg::ACT_ENTER, 10'd1023);   // top taken, wraps to slot 0 side
        send_request(cffa_pkg::ACT_EXIT,  10'd1);
        send_request(cffa_pkg::ACT_ENTER, 10'd0);      // picks up the freed slot
        send_request(cffa_pkg::ACT_EXIT,  10'd1023);
        send_request(cffa_pkg::ACT_EXIT,  10'd1023);   // freeing a free slot leaves it free
        send_request(cffa_pkg::ACT_ENTER, 10'd1023);
        send_request(cffa_pkg::ACT_ENTER, 10'd512);
        send_request(cffa_pkg::ACT_EXIT,  10'd700);    // already free
    endtask

    // tiny count: fill it, report full, out-of-range enters and exits
    task automatic test_small_count();
        set_slot_count(11'd4);
        send_request(cffa_pkg::ACT_ENTER, 10'd3);
        send_request(cffa_pkg::ACT_ENTER, 10'd3);      // all four taken, full
        send_request(cffa_pkg::ACT_ENTER, 10'd700);    // beyond count while full
        send_request(cffa_pkg::ACT_EXIT,  10'd700);    // beyond count, dropped
        send_request(cffa_pkg::ACT_EXIT,  10'd4);      // first slot past the count, dropped
        send_request(cffa_pkg::ACT_EXIT,  10'd2);
        send_request(cffa_pkg::ACT_ENTER, 10'd900);    // beyond count, searches from 0
    endtask

    // zero count, saturated count and a single slot
    task automatic test_count_extremes();
        set_slot_count(11'd0);
        send_request(cffa_pkg::ACT_ENTER, 10'd0);      // nothing in use, full
        send_request(cffa_pkg::ACT_EXIT,  10'd3);      // dropped
        set_slot_count(11'd2047);                      // saturates to the full store
        send_request(cffa_pkg::ACT_ENTER, 10'd1023);
        send_request(cffa_pkg::ACT_EXIT,  10'd1023);
        send_request(cffa_pkg::ACT_ENTER, 10'd1023);
        set_slot_count(11'd1);
        send_request(cffa_pkg::ACT_ENTER, 10'd5);      // slot 0 still taken, full
        send_request(cffa_pkg::ACT_EXIT,  10'd0);
        send_request(cffa_pkg::ACT_ENTER, 10'd1023);
    endtask

    // results stall for a long stretch while enter requests keep coming,
    // so the result register fills and the request side backs up
    task automatic test_result_backpressure();
        set_slot_count(cffa_pkg::COUNT_RESET);
        steady_flow = 1'b1;
        hold_cycles = HOLD_LEN;
        for (int k = 0; k < BURST_LEN; k++)
            send_request(cffa_pkg::ACT_ENTER,
                         cffa_pkg::SLOT_W'($urandom_range(0, cffa_pkg::MAX_SLOTS - 1)));
        steady_flow = 1'b0;
        settle_block();
    endtask

    // one random phase at a given count; exits mostly aim at taken slots,
    // a tenth of requests name any slot at all
    task automatic run_traffic_phase(input logic [cffa_pkg::COUNT_W-1:0] count,
                                     input int items, input int enter_pct);
        int                n;
        int                s;
        cffa_pkg::t_action act;
        set_slot_count(count);
        n = active_count();
        for (int k = 0; k < items; k++) begin
            act = ($urandom_range(0, 99) < enter_pct) ? cffa_pkg::ACT_ENTER
                                                      : cffa_pkg::ACT_EXIT;
            if (n == 0 || $urandom_range(0, 9) == 0) begin
                s = $urandom_range(0, cffa_pkg::MAX_SLOTS - 1);
            end else begin
                s = $urandom_range(0, n - 1);
                if (act == cffa_pkg::ACT_EXIT)
                    for (int t = 0; t < 8 && free_bits[s]; t++) s = $urandom_range(0, n - 1);
            end
            send_request(act, cffa_pkg::SLOT_W'(s));
        end
    endtask

    // small counts fill and go full often, large ones wrap over a sparse map
    task automatic test_random_traffic();
        run_traffic_phase(11'd1, 60, 60);
        run_traffic_phase(11'd2, 60, 55);
        run_traffic_phase(11'd32, 120, 65);
        steady_flow = 1'b1;
        run_traffic_phase(11'd33, 120, 60);
        steady_flow = 1'b0;
        run_traffic_phase(11'd100, 120, 70);
        run_traffic_phase(cffa_pkg::COUNT_RESET, 150, 85);
        steady_flow = 1'b1;
        run_traffic_phase(11'd2047, 100, 60);
        steady_flow = 1'b0;
        run_traffic_phase(cffa_pkg::COUNT_W'($urandom_range(0, 2047)), 120, 60);
        run_traffic_phase(cffa_pkg::COUNT_W'($urandom_range(1, cffa_pkg::MAX_SLOTS)),
                          120, 60);
    endtask

    // ---------------------------------------------------------------------
    // sequence
    // ---------------------------------------------------------------------
    initial begin : test_sequence
        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_wdata    <= '0;
        req_bus.valid  <= 1'b0;
        req_bus.action <= cffa_pkg::ACT_ENTER;
        req_bus.slot   <= '0;
        free_bits  = '1;
        slot_count = cffa_pkg::COUNT_RESET;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_wrap_search();
        test_small_count();
        test_count_extremes();
        test_result_backpressure();
        test_random_traffic();
        settle_block();

        $display("covered %0d enter and %0d exit requests over %0d slot count writes",
                 enters_sent, exits_sent, counts_used);
        $display("checked %0d grants and %0d full responses, %0d mismatches",
                 grants_seen, fulls_seen, mismatches);
        if (mismatches == 0) begin
            $display("tb_circular_first_free_slot_allocator_top: PASS");
        end else begin
            $display("tb_circular_first_free_slot_allocator_top: FAIL");
        end
        $finish;
    end

    // hang guard, many times the slowest legal run
    initial begin : run_limit
        #5_000_000;
        $display("%0t: timeout with %0d grants outstanding", $time, pending_grants.size());
        $display("tb_circular_first_free_slot_allocator_top: FAIL");
        $finish;
    end

endmodule

[circular_first_free_slot_allocator_top.f]
sv/cffa_pkg.sv
sv/cffa_req_if.sv
sv/cffa_res_if.sv
sv/cffa_engine.sv
sv/circular_first_free_slot_allocator_top.sv
bench/tb_circular_first_free_slot_allocator_top.sv
